// File: hw/rtl/lbvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared constants and types for the vertex skinning block.
// ----------------------------------------------------------------------------
package lbvs_pkg;

  localparam int MaxBones   = 64;
  localparam int Influences = 4;
  localparam int Elems      = 12;
  localparam int PalDepth   = MaxBones * Elems;
  localparam int PalAw      = $clog2(PalDepth);
  localparam int AccW       = 52;

  typedef logic [PalAw-1:0] pal_addr_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef acc_t vec3_t [3];

endpackage
`default_nettype wire

// File: hw/rtl/linear_blend_vertex_skinning_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_top
// Four-influence linear blend skinning over a 64-matrix Q4.12 palette.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser low loads one palette element and gives no
// result; tuser high skins one vertex and gives one result on m_*.
// A vertex runs through one shared 33x33 multiplier: per influence three
// rows, each four palette reads with nine products plus three weight
// products. Normal and tangent are then normalised side by side (range
// shift of up to 20 steps, 3 squaring steps, 32 square-root steps and a
// restoring divide per component), with an early zero result for a zero
// direction. s_tready is low while a vertex is in progress. The result
// waits in an output register; a stalled receiver holds the block only
// at the point where the next result would be written, and load requests
// are still taken while a result waits.
// Reset clears the control state; palette contents are undefined until
// written and need no clearing.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // bone_slot, element_index, element_value, position_xyz, normal_xyz,
  // tangent_xyz, tangent_sign, bone_indices, bone_weights, zero pad
  input  wire logic [279:0] s_tdata,
  // action
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // skinned_position_xyz, skinned_normal_xyz, skinned_tangent_xyz,
  // skinned_tangent_sign
  output logic [159:0]      m_tdata
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_ADDR  = 8'b00000010,
    S_MUL   = 8'b00000100,
    S_WMUL  = 8'b00001000,
    S_DRAIN = 8'b00010000,
    S_START = 8'b00100000,
    S_NORM  = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  localparam int JW = $clog2(lbvs_pkg::Influences);

  state_t state;

  logic [47:0] pos_q, nrm_q, tan_q;
  logic [15:0] tsgn_q;
  logic [23:0] idx_q;
  logic [63:0] wts_q;

  logic [JW-1:0] j;
  logic [1:0]    r, k, u;

  logic signed [32:0] rowsum [3];
  lbvs_pkg::vec3_t    acc [3];

  logic signed [32:0] mul_a, mul_b;
  logic               mul_go, mul_acc;
  logic signed [65:0] prod;
  logic               pend, pend_acc;
  logic [1:0]         pend_u, pend_r;

  logic [5:0]  slot, bone;
  logic [3:0]  el;
  logic [15:0] w;
  logic        accept, ld_ok, bone_ok, ram_en, ram_we, n_busy, t_busy, norm_go;
  lbvs_pkg::pal_addr_t ram_addr;
  logic [15:0] ram_rdata;
  logic [15:0] comp;
  logic [47:0] nres, tres, posv;
  logic signed [51:0] pr [3];
  logic signed [24:0] pv [3];

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign slot     = s_tdata[5:0];
  assign el       = s_tdata[9:6];
  assign ld_ok    = ({3'b0, slot} < 9'(lbvs_pkg::MaxBones)) &&
                    ({1'b0, el} < 5'(lbvs_pkg::Elems));
  assign bone     = idx_q[6*j +: 6];
  assign w        = wts_q[16*j +: 16];
  assign bone_ok  = ({3'b0, bone} < 9'(lbvs_pkg::MaxBones));
  assign norm_go  = (state == S_START);

  always_comb begin
    ram_we   = accept && !s_tuser && ld_ok;
    ram_en   = ram_we || (state == S_ADDR && bone_ok);
    if (state == S_IDLE) begin
      ram_addr = lbvs_pkg::pal_addr_t'(slot) * lbvs_pkg::pal_addr_t'(lbvs_pkg::Elems)
                 + lbvs_pkg::pal_addr_t'(el);
    end else begin
      ram_addr = lbvs_pkg::pal_addr_t'(bone) * lbvs_pkg::pal_addr_t'(lbvs_pkg::Elems)
                 + lbvs_pkg::pal_addr_t'({r, k});
    end
  end

  lbvs_ram #(
    .WIDTH(16),
    .DEPTH(lbvs_pkg::PalDepth)
  ) u_palette (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(s_tdata[25:10]),
    .rdata(ram_rdata)
  );

  always_comb begin
    case (u)
      2'd0:    comp = pos_q[16*k +: 16];
      2'd1:    comp = nrm_q[16*k +: 16];
      default: comp = tan_q[16*k +: 16];
    endcase
    mul_go  = 1'b0;
    mul_acc = 1'b0;
    mul_a   = 33'(signed'(ram_rdata));
    mul_b   = 33'(signed'(comp));
    if (state == S_MUL && k != 2'd3) begin
      mul_go = 1'b1;
    end else if (state == S_WMUL) begin
      mul_go  = 1'b1;
      mul_acc = 1'b1;
      mul_a   = rowsum[u];
      mul_b   = signed'({17'b0, w});
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr[i] = acc[0][i] + 52'sd67108864;
      pv[i] = signed'(pr[i][51:27]);
      if (pv[i] > 25'sd32767) begin
        posv[16*i +: 16] = 16'h7FFF;
      end else if (pv[i] < -25'sd32768) begin
        posv[16*i +: 16] = 16'h8000;
      end else begin
        posv[16*i +: 16] = pv[i][15:0];
      end
    end
  end

  lbvs_norm u_norm_n (
    .clk  (clk),
    .rst  (rst),
    .start(norm_go),
    .vec  (acc[1]),
    .busy (n_busy),
    .res  (nres)
  );

  lbvs_norm u_norm_t (
    .clk  (clk),
    .rst  (rst),
    .start(norm_go),
    .vec  (acc[2]),
    .busy (t_busy),
    .res  (tres)
  );

  always_ff @(posedge clk) begin
    prod     <= mul_a * mul_b;
    pend_u   <= u;
    pend_r   <= r;
    pend_acc <= mul_acc;
    if (pend) begin
      if (pend_acc) begin
        acc[pend_u][pend_r] <= acc[pend_u][pend_r] + prod[51:0];
      end else begin
        rowsum[pend_u] <= rowsum[pend_u] + prod[32:0];
      end
    end
    if (state == S_ADDR && k == 2'd0) begin
      rowsum[0] <= 33'sd0;
      rowsum[1] <= 33'sd0;
      rowsum[2] <= 33'sd0;
    end
    if (state == S_MUL && k == 2'd3) begin
      rowsum[0] <= rowsum[0] + 33'({{9{ram_rdata[15]}}, ram_rdata, 8'b0});
    end
    if (accept && s_tuser) begin
      pos_q  <= s_tdata[73:26];
      nrm_q  <= s_tdata[121:74];
      tan_q  <= s_tdata[169:122];
      tsgn_q <= s_tdata[185:170];
      idx_q  <= s_tdata[209:186];
      wts_q  <= s_tdata[273:210];
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          acc[a][b] <= '0;
        end
      end
    end
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {tsgn_q, tres, nres, posv};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
      j        <= '0;
      r        <= 2'd0;
      k        <= 2'd0;
      u        <= 2'd0;
    end else begin
      pend <= mul_go;
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && s_tuser) begin
            j     <= '0;
            r     <= 2'd0;
            k     <= 2'd0;
            u     <= 2'd0;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (!bone_ok) begin
            if (j == JW'(lbvs_pkg::Influences - 1)) begin
              state <= S_DRAIN;
            end else begin
              j <= j + 1'b1;
            end
          end else begin
            u     <= 2'd0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (k == 2'd3) begin
            k     <= 2'd0;
            u     <= 2'd0;
            state <= S_WMUL;
          end else if (u == 2'd2) begin
            k     <= k + 2'd1;
            state <= S_ADDR;
          end else begin
            u <= u + 2'd1;
          end
        end
        S_WMUL: begin
          if (u == 2'd2) begin
            u <= 2'd0;
            if (r == 2'd2) begin
              r <= 2'd0;
              if (j == JW'(lbvs_pkg::Influences - 1)) begin
                state <= S_DRAIN;
              end else begin
                j     <= j + 1'b1;
                state <= S_ADDR;
              end
            end else begin
              r     <= r + 2'd1;
              state <= S_ADDR;
            end
          end else begin
            u <= u + 2'd1;
          end
        end
        S_DRAIN: state <= S_START;
        S_START: state <= S_NORM;
        S_NORM: begin
          if (!n_busy && !t_busy) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lbvs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbvs_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module lbvs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 768
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lbvs_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbvs_norm
// Iterative direction normaliser: range shift, sum of squares, bitwise
// square root and restoring division, giving Q1.14 unit components.
// ----------------------------------------------------------------------------
module lbvs_norm (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  lbvs_pkg::vec3_t     vec,
  output logic                busy,
  output logic [47:0]         res
);

  typedef enum logic [7:0] {
    N_IDLE  = 8'b00000001,
    N_SCAN  = 8'b00000010,
    N_SHIFT = 8'b00000100,
    N_SQ    = 8'b00001000,
    N_SQE   = 8'b00010000,
    N_ROOT  = 8'b00100000,
    N_DINIT = 8'b01000000,
    N_DIV   = 8'b10000000
  } norm_state_t;

  norm_state_t state;

  lbvs_pkg::acc_t c [3];
  logic [51:0] maxabs;
  logic [61:0] sum;
  logic [61:0] sq;
  logic        sq_pend;
  logic [1:0]  idx;
  logic [61:0] rn;
  logic [62:0] rr;
  logic [62:0] bitv;
  logic [4:0]  cnt;
  logic [30:0] len;
  logic [30:0] rem;
  logic [15:0] lo;
  logic [3:0]  dcnt;
  logic [1:0]  comp;

  logic [51:0] a0, a1, a2, ac;
  logic [51:0] mx01, mx;
  logic [62:0] tr;
  logic [31:0] tq;
  logic        qbit;
  logic [15:0] qf;
  logic [15:0] mag;
  logic [44:0] num;
  logic [61:0] sum_fin;

  function automatic logic [51:0] absv(input lbvs_pkg::acc_t v);
    absv = v[51] ? 52'(-v) : 52'(v);
  endfunction

  always_comb begin
    a0   = absv(c[0]);
    a1   = absv(c[1]);
    a2   = absv(c[2]);
    mx01 = (a1 > a0) ? a1 : a0;
    mx   = (a2 > mx01) ? a2 : mx01;
    case ((state == N_SQ) ? idx : comp)
      2'd0:    ac = a0;
      2'd1:    ac = a1;
      default: ac = a2;
    endcase
    tr      = rr + bitv;
    tq      = {rem, lo[15]};
    qbit    = (tq >= {1'b0, len});
    qf      = {lo[14:0], qbit};
    mag     = (qf > 16'd32767) ? 16'd32767 : qf;
    num     = {ac[30:0], 14'b0} + 45'(rr[30:1]);
    sum_fin = sq_pend ? sum + sq : sum;
  end

  assign busy = (state != N_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= N_IDLE;
      sq_pend <= 1'b0;
    end else begin
      sq_pend <= 1'b0;
      unique case (state)
        N_IDLE: begin
          if (start) begin
            c[0]  <= vec[0];
            c[1]  <= vec[1];
            c[2]  <= vec[2];
            state <= N_SCAN;
          end
        end
        N_SCAN: begin
          maxabs <= mx;
          if (mx == 52'd0) begin
            res   <= 48'd0;
            state <= N_IDLE;
          end else begin
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (maxabs >= 52'(64'd1 << 30)) begin
            maxabs <= maxabs >> 1;
            c[0]   <= c[0] >>> 1;
            c[1]   <= c[1] >>> 1;
            c[2]   <= c[2] >>> 1;
          end else begin
            sum   <= 62'd0;
            idx   <= 2'd0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          sq      <= 62'(ac[30:0] * ac[30:0]);
          sq_pend <= 1'b1;
          if (sq_pend) sum <= sum + sq;
          if (idx == 2'd2) begin
            state <= N_SQE;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        N_SQE: begin
          rn    <= sum_fin;
          rr    <= 63'd0;
          bitv  <= 63'(64'd1 << 62);
          cnt   <= 5'd0;
          state <= N_ROOT;
        end
        N_ROOT: begin
          if ({1'b0, rn} >= tr) begin
            rn <= rn - tr[61:0];
            rr <= (rr >> 1) + bitv;
          end else begin
            rr <= rr >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            comp  <= 2'd0;
            state <= N_DINIT;
          end
        end
        N_DINIT: begin
          len <= rr[30:0];
          if (rr[30:0] == 31'd0) begin
            res   <= 48'd0;
            state <= N_IDLE;
          end else begin
            rem   <= 31'({2'b0, num[44:16]});
            lo    <= num[15:0];
            dcnt  <= 4'd0;
            state <= N_DIV;
          end
        end
        N_DIV: begin
          if (qbit) begin
            rem <= 31'(tq - {1'b0, len});
          end else begin
            rem <= tq[30:0];
          end
          lo   <= qf;
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd15) begin
            res[16*comp +: 16] <= c[comp][51] ? 16'(-mag) : mag;
            if (comp == 2'd2) begin
              state <= N_IDLE;
            end else begin
              comp  <= comp + 2'd1;
              state <= N_DINIT;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-influence vertex skinning block. Palette
// loads and vertex requests go in on the slave stream; every skinned vertex
// is predicted in fixed point on acceptance and compared field by field on
// the master stream, under random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam logic ActLoad = 1'b0;
  localparam logic ActSkin = 1'b1;
  localparam int   CycleLimit = 3000000;

  typedef struct {
    logic        action;
    logic [5:0]  slot;
    logic [3:0]  elem;
    logic [15:0] value;
    logic [47:0] pos;
    logic [47:0] nrm;
    logic [47:0] tan;
    logic [15:0] tsign;
    logic [23:0] idx;
    logic [63:0] wts;
  } vtx_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [279:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [159:0] m_tdata;

  logic [15:0]  palette [lbvs_pkg::MaxBones*lbvs_pkg::Elems];
  bit           written [lbvs_pkg::MaxBones*lbvs_pkg::Elems];
  logic [159:0] skinned_q [$];
  int           mismatches = 0;
  int           sent = 0;
  bit           no_idle = 1'b0;
  logic         hold_go = 1'b0;
  int           hold_cnt = 0;
  longint       cycles = 0;

  linear_blend_vertex_skinning_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random idling, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_cnt <= 800;
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [159:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (skinned_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = skinned_q.pop_front();
        for (int f = 0; f < 4; f++) begin
          logic [47:0] got, want_f;
          if (f == 3) begin
            got    = {32'd0, m_tdata[159:144]};
            want_f = {32'd0, want[159:144]};
          end else begin
            got    = m_tdata[f*48 +: 48];
            want_f = want[f*48 +: 48];
          end
          if (got !== want_f) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d mismatch: expected %h, got %h", f, want_f, got);
          end
        end
      end
    end
  end

  function automatic longint sx16(input logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned mag64(input longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [47:0] unit_dir(input longint v [3]);
    longint unsigned mx, sum, len, m;
    longint c [3];
    logic [47:0] o;
    int s;
    mx = 0;
    sum = 0;
    s = 0;
    o = '0;
    for (int i = 0; i < 3; i++) if (mag64(v[i]) > mx) mx = mag64(v[i]);
    if (mx == 0) return '0;
    while ((mx >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      c[i] = v[i] >>> s;
      sum += mag64(c[i]) * mag64(c[i]);
    end
    len = isqrt(sum);
    if (len == 0) return '0;
    for (int i = 0; i < 3; i++) begin
      m = (mag64(c[i]) * 16384 + len / 2) / len;
      if (m > 32767) m = 32767;
      o[i*16 +: 16] = c[i] < 0 ? 16'(-longint'(m)) : 16'(m);
    end
    return o;
  endfunction

  function automatic logic [159:0] skin_vertex(input vtx_req_t r);
    longint p [3], n [3], t [3], ap [3], an [3], at [3], m [4], w, v;
    logic [47:0] pq;
    int b;
    for (int i = 0; i < 3; i++) begin
      p[i] = sx16(r.pos[i*16 +: 16]);
      n[i] = sx16(r.nrm[i*16 +: 16]);
      t[i] = sx16(r.tan[i*16 +: 16]);
      ap[i] = 0; an[i] = 0; at[i] = 0;
    end
    for (int j = 0; j < lbvs_pkg::Influences; j++) begin
      b = r.idx[j*6 +: 6];
      w = longint'(r.wts[j*16 +: 16]);
      for (int row = 0; row < 3; row++) begin
        for (int k = 0; k < 4; k++)
          m[k] = sx16(palette[b*lbvs_pkg::Elems + row*4 + k]);
        ap[row] += (m[0]*p[0] + m[1]*p[1] + m[2]*p[2] + m[3]*256) * w;
        an[row] += (m[0]*n[0] + m[1]*n[1] + m[2]*n[2]) * w;
        at[row] += (m[0]*t[0] + m[1]*t[1] + m[2]*t[2]) * w;
      end
    end
    for (int i = 0; i < 3; i++) begin
      v = (ap[i] + (64'sd1 <<< 26)) >>> 27;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      pq[i*16 +: 16] = v[15:0];
    end
    return {r.tsign, unit_dir(at), unit_dir(an), pq};
  endfunction

  function automatic bit bone_ready(input int b);
    for (int e = 0; e < lbvs_pkg::Elems; e++)
      if (!written[b*lbvs_pkg::Elems + e]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic send_request(input vtx_req_t r);
    if (!no_idle && $urandom_range(99) < 37) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.action;
    s_tdata  <= {6'd0, r.wts, r.idx, r.tsign, r.tan, r.nrm, r.pos, r.value, r.elem, r.slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (r.action == ActLoad) begin
      if (r.elem < lbvs_pkg::Elems) begin
        palette[r.slot*lbvs_pkg::Elems + r.elem] = r.value;
        written[r.slot*lbvs_pkg::Elems + r.elem] = 1'b1;
      end
    end else begin
      skinned_q.push_back(skin_vertex(r));
    end
  endtask

  task automatic load_elem(input int b, input int e, input logic [15:0] val);
    vtx_req_t r;
    r = '{default: '0};
    r.action = ActLoad;
    r.slot = 6'(b);
    r.elem = 4'(e);
    r.value = val;
    r.pos = 48'({$urandom, $urandom});
    send_request(r);
  endtask

  task automatic skin(input logic [47:0] pos, nrm, tan, input logic [15:0] ts,
                      input logic [23:0] idx, input logic [63:0] wts);
    vtx_req_t r;
    r = '{default: '0};
    r.action = ActSkin;
    r.pos = pos; r.nrm = nrm; r.tan = tan; r.tsign = ts; r.idx = idx; r.wts = wts;
    r.slot = 6'($urandom);
    r.value = 16'($urandom);
    send_request(r);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (skinned_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [23:0] pick_bones();
    logic [23:0] idx;
    int b;
    for (int j = 0; j < 4; j++) begin
      do b = $urandom_range(lbvs_pkg::MaxBones-1); while (!bone_ready(b));
      idx[j*6 +: 6] = 6'(b);
    end
    return idx;
  endfunction

  function automatic logic [47:0] rnd_vec();
    case ($urandom_range(3))
      0: return 48'({$urandom, $urandom});
      1: return {16'($urandom_range(255)) - 16'd128, 16'($urandom_range(255)) - 16'd128,
                 16'($urandom_range(255)) - 16'd128};
      2: return '0;
      default: return {16'sd0, -16'sd9000, 16'sd13000};
    endcase
  endfunction

  function automatic logic [63:0] rnd_weights();
    logic [15:0] a, b, c;
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return 64'h0000_0000_0000_8000;
      2: return 64'hFFFF_FFFF_FFFF_FFFF;
      default: begin
        a = 16'($urandom_range(32768));
        b = 16'($urandom_range(32768 - a));
        c = 16'($urandom_range(32768 - a - b));
        return {16'(32768 - a - b - c), c, b, a};
      end
    endcase
  endfunction

  // identity in slot 0, two out-of-range element loads, extreme values in slot 63, then the corner vertices
  task automatic test_directed();
    for (int e = 0; e < lbvs_pkg::Elems; e++)
      load_elem(0, e, (e == 0 || e == 5 || e == 10) ? 16'h1000 : 16'h0000);
    load_elem(0, 12, 16'h7FFF);
    load_elem(5, 15, 16'h8000);
    for (int e = 0; e < lbvs_pkg::Elems; e++) load_elem(63, e, e[0] ? 16'h8000 : 16'h7FFF);
    skin(48'h7FFF_8000_7FFF, 48'h0000_0000_4000, 48'h4000_0000_0000, 16'h8000,
         24'h0, 64'h0000_0000_0000_8000);
    skin(48'h8000_7FFF_8000, 48'h0, 48'h0, 16'h7FFF, 24'hFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    skin(48'h7FFF_7FFF_7FFF, 48'hC000_C000_C000, 48'h7FFF_8000_0001, 16'h0000,
         {6'd63, 6'd0, 6'd63, 6'd0}, 64'hFFFF_0001_8000_7FFF);
    skin(48'h0100_0100_0100, 48'h0001_0000_0000, 48'h0, 16'h1234, 24'h0, 64'h0);
    wait_drain();
  endtask

  // full matrices with random content and stray single-element loads, followed by vertices over fully written bones
  task automatic test_random(input int total);
    int b;
    while (sent < total) begin
      if ($urandom_range(3) == 0) begin
        b = $urandom_range(lbvs_pkg::MaxBones-1);
        for (int e = 0; e < lbvs_pkg::Elems; e++)
          load_elem(b, e, ($urandom_range(7) == 0) ? ($urandom_range(1) ? 16'h7FFF : 16'h8000)
                                                   : 16'($urandom));
      end
      if ($urandom_range(4) == 0)
        load_elem($urandom_range(lbvs_pkg::MaxBones-1), $urandom_range(15), 16'($urandom));
      repeat ($urandom_range(1, 3))
        skin(rnd_vec(), rnd_vec(), rnd_vec(), 16'($urandom), pick_bones(), rnd_weights());
    end
  endtask

  // receiver holds off while the sender keeps offering requests
  task automatic test_backpressure();
    s_tvalid <= 1'b0;
    hold_go  <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 4; i++) begin
      skin(rnd_vec(), rnd_vec(), rnd_vec(), 16'($urandom), pick_bones(), rnd_weights());
      load_elem(0, 0, 16'h1000);
    end
    wait_drain();
  endtask

  task automatic test_no_idle();
    no_idle = 1'b1;
    test_random(sent + 40);
    no_idle = 1'b0;
    wait_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_backpressure();
    test_no_idle();
    test_random(750);
    wait_drain();
    if (mismatches == 0 && skinned_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/lbvs_pkg.sv
hw/rtl/lbvs_ram.sv
hw/rtl/lbvs_norm.sv
hw/rtl/linear_blend_vertex_skinning_top.sv
tb/tb.sv
